[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the sorted timer queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define STQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define STQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared codes, types and stream widths.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 48;

   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_SET   = 2'd2,
      CMD_NOP   = 2'd3
   } stq_cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_QUEUED  = 2'd2
   } stq_status_type;

   typedef enum logic [1:0] {
      MARK_FREE   = 2'd0,
      MARK_ALLOC  = 2'd1,
      MARK_QUEUED = 2'd2
   } stq_mark_type;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_DECODE   = 12'b0000_0000_0010,
      S_SCAN     = 12'b0000_0000_0100,
      S_HEAD_RD  = 12'b0000_0000_1000,
      S_WALK     = 12'b0000_0001_0000,
      S_WR_A     = 12'b0000_0010_0000,
      S_WR_B     = 12'b0000_0100_0000,
      S_U_HEAD   = 12'b0000_1000_0000,
      S_U_WALK   = 12'b0001_0000_0000,
      S_U_SPLICE = 12'b0010_0000_0000,
      S_U_DL     = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } stq_state_type;

   // write strobes toward the slot memory
   typedef struct packed {
      logic we_deadline;
      logic we_link;
   } stq_wr_ctl_type;

endpackage

[hw/rtl/sorted_timer_queue.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer slot pool with a deadline-ordered linked queue, run by a sequencer.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata fields (low bit up)                      | tuser
//   --------+-----+------------------------------------------------+---------
//   req_    | in  | slot[3:0] timeout[35:4] current_time[67:36]    | command
//   rsp_    | out | status[1:0] granted_slot[5:2]                  | -
//           |     | next_deadline[37:6] queue_length[42:38]        |
//
// One request at a time. A transfer goes through accept, decode, the
// command's work and the load of the result register:
//   allocate: mark scan from slot 0 up to the lowest free slot, one a cycle
//   settime:  direct write at the head or into an empty queue, else a walk
//             (one link per cycle through the slot memory read port)
//   free:     mark only if unqueued, unlink at the head, else walk and splice
// Reset is synchronous and clears marks, queue head, length and deadline; the
// slot memory holds no reset state. A stalled result sits in the output
// register while the next request is already taken and worked on.
//
module sorted_timer_queue #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot[3:0], timeout[35:4], current_time[67:36], zero pad
   input  logic [stq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [stq_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], granted_slot[5:2], next_deadline[37:6],
   // queue_length[42:38], zero pad
   output logic [stq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

`include "assert_macros.svh"

   localparam int SW = $clog2(SLOT_COUNT);       // slot index
   localparam int LW = $clog2(SLOT_COUNT + 1);   // link, holds "none" = SLOT_COUNT
   localparam int CW = $clog2(SLOT_COUNT + 1);   // queue length
   localparam logic [LW-1:0] NO_LINK = LW'(SLOT_COUNT);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

   // sequencer and request registers
   stq_pkg::stq_state_type  state_ff, state_in;
   stq_pkg::stq_cmd_type    cmd_ff, cmd_in;
   logic [3:0]              slot_ff, slot_in;
   logic [31:0]             dl_ff, dl_in;          // deadline of the settime
   logic [SW-1:0]           idx_ff, idx_in;        // allocate scan pointer
   logic [SW-1:0]           t_ff, t_in;            // entry whose link may change
   logic [LW-1:0]           nx_ff, nx_in;          // successor of the new entry
   stq_pkg::stq_status_type status_ff, status_in;
   logic [3:0]              granted_ff, granted_in;

   // queue state
   logic [SW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [31:0]             earliest_ff, earliest_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [3:0]              rsp_granted_ff, rsp_granted_in;
   logic [31:0]             rsp_deadline_ff, rsp_deadline_in;
   logic [4:0]              rsp_length_ff, rsp_length_in;

   // memory and mark file hookup
   logic [SW-1:0]           mem_rd_addr;
   logic [31:0]             mem_rd_deadline;
   logic [LW-1:0]           mem_rd_link;
   stq_pkg::stq_wr_ctl_type mem_wr_ctl;
   logic [SW-1:0]           mem_wr_addr;
   logic [31:0]             mem_wr_deadline;
   logic [LW-1:0]           mem_wr_link;

   logic [SW-1:0]           mark_rd_addr;
   stq_pkg::stq_mark_type   mark_rd;
   logic                    mark_we;
   logic [SW-1:0]           mark_wr_addr;
   stq_pkg::stq_mark_type   mark_wr;

   // shared deadline comparator: new deadline against head or walked entry
   logic [31:0]             cmp_b;
   logic                    cmp_le;

   logic [SW-1:0]           slot_idx;
   logic                    in_pool;
   logic                    link_none;

   // assertion helpers
   logic                    chk_idle_empty;   // idle with nothing queued
   logic                    chk_no_deadline;
   logic                    chk_in_done;
   logic                    chk_rsp_failed;   // result on offer, failed status

   assign slot_idx  = SW'(slot_ff);
   assign in_pool   = 32'(slot_ff) < SLOT_COUNT;
   assign link_none = mem_rd_link >= NO_LINK;
   assign cmp_b     = (state_ff == stq_pkg::S_WALK) ? mem_rd_deadline : earliest_ff;
   assign cmp_le    = dl_ff <= cmp_b;

   stq_slot_mem #(
      .DEPTH (SLOT_COUNT),
      .AW    (SW),
      .LW    (LW)
   ) u_mem (
      .clock       (clock),
      .rd_addr     (mem_rd_addr),
      .rd_deadline (mem_rd_deadline),
      .rd_link     (mem_rd_link),
      .wr_ctl      (mem_wr_ctl),
      .wr_addr     (mem_wr_addr),
      .wr_deadline (mem_wr_deadline),
      .wr_link     (mem_wr_link)
   );

   stq_mark_file #(
      .DEPTH (SLOT_COUNT),
      .AW    (SW)
   ) u_marks (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mark_rd_addr),
      .rd_mark (mark_rd),
      .wr_en   (mark_we),
      .wr_addr (mark_wr_addr),
      .wr_mark (mark_wr)
   );

   assign req_tready = (state_ff == stq_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_length_ff, rsp_deadline_ff, rsp_granted_ff,
                        rsp_status_ff};

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      slot_in         = slot_ff;
      dl_in           = dl_ff;
      idx_in          = idx_ff;
      t_in            = t_ff;
      nx_in           = nx_ff;
      status_in       = status_ff;
      granted_in      = granted_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      earliest_in     = earliest_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_granted_in  = rsp_granted_ff;
      rsp_deadline_in = rsp_deadline_ff;
      rsp_length_in   = rsp_length_ff;

      mem_rd_addr     = t_ff;
      mem_wr_ctl      = '0;
      mem_wr_addr     = t_ff;
      mem_wr_deadline = dl_ff;
      mem_wr_link     = LW'(slot_idx);

      mark_rd_addr    = (state_ff == stq_pkg::S_SCAN) ? idx_ff : slot_idx;
      mark_we         = 1'b0;
      mark_wr_addr    = slot_idx;
      mark_wr         = stq_pkg::MARK_FREE;

      unique case (state_ff)
         stq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = stq_pkg::stq_cmd_type'(req_tuser);
               slot_in    = req_tdata[3:0];
               dl_in      = req_tdata[67:36] + req_tdata[35:4];
               idx_in     = '0;
               status_in  = stq_pkg::ST_OK;
               granted_in = 4'd0;
               state_in   = stq_pkg::S_DECODE;
            end
         end

         stq_pkg::S_DECODE: begin
            unique case (cmd_ff)
               stq_pkg::CMD_ALLOC: begin
                  state_in = stq_pkg::S_SCAN;
               end
               stq_pkg::CMD_FREE: begin
                  if (!in_pool) begin
                     state_in = stq_pkg::S_DONE;
                  end else begin
                     mark_we = 1'b1;
                     if (mark_rd != stq_pkg::MARK_QUEUED) begin
                        state_in = stq_pkg::S_DONE;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (head_ff == slot_idx) begin
                           mem_rd_addr = slot_idx;
                           state_in    = stq_pkg::S_U_HEAD;
                        end else begin
                           mem_rd_addr = head_ff;
                           t_in        = head_ff;
                           state_in    = stq_pkg::S_U_WALK;
                        end
                     end
                  end
               end
               stq_pkg::CMD_SET: begin
                  priority if (!in_pool) begin
                     state_in = stq_pkg::S_DONE;
                  end else if (mark_rd == stq_pkg::MARK_QUEUED) begin
                     status_in = stq_pkg::ST_QUEUED;
                     state_in  = stq_pkg::S_DONE;
                  end else if (count_ff == '0) begin
                     head_in     = slot_idx;
                     earliest_in = dl_ff;
                     nx_in       = NO_LINK;
                     state_in    = stq_pkg::S_WR_B;
                  end else if (cmp_le) begin
                     // ties go in front of the head
                     nx_in       = LW'(head_ff);
                     head_in     = slot_idx;
                     earliest_in = dl_ff;
                     state_in    = stq_pkg::S_WR_B;
                  end else begin
                     mem_rd_addr = head_ff;
                     t_in        = head_ff;
                     state_in    = stq_pkg::S_HEAD_RD;
                  end
               end
               default: begin
                  state_in = stq_pkg::S_DONE;
               end
            endcase
         end

         stq_pkg::S_SCAN: begin
            priority if (mark_rd == stq_pkg::MARK_FREE) begin
               mark_we      = 1'b1;
               mark_wr_addr = idx_ff;
               mark_wr      = stq_pkg::MARK_ALLOC;
               granted_in   = 4'(idx_ff);
               state_in     = stq_pkg::S_DONE;
            end else if (idx_ff == LAST_SLOT) begin
               status_in = stq_pkg::ST_NO_FREE;
               state_in  = stq_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         // link word of the head is in; start the walk or append
         stq_pkg::S_HEAD_RD: begin
            if (link_none) begin
               nx_in    = NO_LINK;
               state_in = stq_pkg::S_WR_A;
            end else begin
               mem_rd_addr = mem_rd_link[SW-1:0];
               nx_in       = mem_rd_link;
               state_in    = stq_pkg::S_WALK;
            end
         end

         // nx_ff is the entry just read; its deadline and link are in
         stq_pkg::S_WALK: begin
            if (cmp_le) begin
               state_in = stq_pkg::S_WR_A;
            end else begin
               t_in = nx_ff[SW-1:0];
               if (link_none) begin
                  nx_in    = NO_LINK;
                  state_in = stq_pkg::S_WR_A;
               end else begin
                  mem_rd_addr = mem_rd_link[SW-1:0];
                  nx_in       = mem_rd_link;
               end
            end
         end

         stq_pkg::S_WR_A: begin
            mem_wr_ctl.we_link = 1'b1;
            mem_wr_addr        = t_ff;
            mem_wr_link        = LW'(slot_idx);
            state_in           = stq_pkg::S_WR_B;
         end

         stq_pkg::S_WR_B: begin
            mem_wr_ctl.we_link     = 1'b1;
            mem_wr_ctl.we_deadline = 1'b1;
            mem_wr_addr            = slot_idx;
            mem_wr_link            = nx_ff;
            mem_wr_deadline        = dl_ff;
            mark_we                = 1'b1;
            mark_wr                = stq_pkg::MARK_QUEUED;
            count_in               = count_ff + CW'(1);
            state_in               = stq_pkg::S_DONE;
         end

         // head removed: link of the old head becomes the new head, or the queue empties
         stq_pkg::S_U_HEAD: begin
            if (link_none || count_ff == '0) begin
               head_in     = '0;
               earliest_in = stq_pkg::ALL_ONES;
               state_in    = stq_pkg::S_DONE;
            end else begin
               head_in     = mem_rd_link[SW-1:0];
               mem_rd_addr = mem_rd_link[SW-1:0];
               state_in    = stq_pkg::S_U_DL;
            end
         end

         stq_pkg::S_U_DL: begin
            earliest_in = mem_rd_deadline;
            state_in    = stq_pkg::S_DONE;
         end

         // link word of t_ff is in
         stq_pkg::S_U_WALK: begin
            priority if (link_none) begin
               state_in = stq_pkg::S_DONE;
            end else if (mem_rd_link == LW'(slot_idx)) begin
               mem_rd_addr = slot_idx;
               state_in    = stq_pkg::S_U_SPLICE;
            end else begin
               t_in        = mem_rd_link[SW-1:0];
               mem_rd_addr = mem_rd_link[SW-1:0];
            end
         end

         // bridge predecessor over the freed slot
         stq_pkg::S_U_SPLICE: begin
            mem_wr_ctl.we_link = 1'b1;
            mem_wr_addr        = t_ff;
            mem_wr_link        = mem_rd_link;
            state_in           = stq_pkg::S_DONE;
         end

         stq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_granted_in  = granted_ff;
               rsp_deadline_in = earliest_ff;
               rsp_length_in   = 5'(count_ff);
               state_in        = stq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = stq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stq_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         earliest_ff  <= stq_pkg::ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         earliest_ff  <= earliest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      slot_ff         <= slot_in;
      dl_ff           <= dl_in;
      idx_ff          <= idx_in;
      t_ff            <= t_in;
      nx_ff           <= nx_in;
      status_ff       <= status_in;
      granted_ff      <= granted_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_deadline_ff <= rsp_deadline_in;
      rsp_length_ff   <= rsp_length_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // count and deadline move in different cycles of one command; they only
   // agree once the sequencer is back in idle
   assign chk_idle_empty  = (state_ff == stq_pkg::S_IDLE) && (count_ff == '0);
   assign chk_no_deadline = (earliest_ff == stq_pkg::ALL_ONES);
   assign chk_in_done     = (state_ff == stq_pkg::S_DONE);
   assign chk_rsp_failed  = rsp_valid_ff && (rsp_status_ff != stq_pkg::ST_OK);

   `STQ_ASSERT(a_count_bound, count_ff <= CW'(SLOT_COUNT), "queue length beyond pool size")
   `STQ_ASSERT_IMPL(a_empty_deadline, chk_idle_empty, chk_no_deadline, "deadline on empty queue")
   `STQ_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_ff), $past(chk_in_done), "stray result")
   `STQ_ASSERT_IMPL(a_grant_only_ok, chk_rsp_failed, rsp_granted_ff == 4'd0, "failed grant")

endmodule

[hw/rtl/stq_slot_mem.sv]
// ----------------------------------------------------------------------------
// Slot memory
// Deadline and link words per slot; one write, one registered read a cycle.
// ----------------------------------------------------------------------------
module stq_slot_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int LW    = 5
) (
   input  logic                    clock,
   input  logic [AW-1:0]           rd_addr,
   output logic [31:0]             rd_deadline,
   output logic [LW-1:0]           rd_link,
   input  stq_pkg::stq_wr_ctl_type wr_ctl,
   input  logic [AW-1:0]           wr_addr,
   input  logic [31:0]             wr_deadline,
   input  logic [LW-1:0]           wr_link
);

   logic [31:0]   deadline_mem [DEPTH];
   logic [LW-1:0] link_mem     [DEPTH];
   logic [31:0]   rd_deadline_ff;
   logic [LW-1:0] rd_link_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.we_deadline) begin
         deadline_mem[wr_addr] <= wr_deadline;
      end
      if (wr_ctl.we_link) begin
         link_mem[wr_addr] <= wr_link;
      end
      rd_deadline_ff <= deadline_mem[rd_addr];
      rd_link_ff     <= link_mem[rd_addr];
   end

   assign rd_deadline = rd_deadline_ff;
   assign rd_link     = rd_link_ff;

endmodule

[hw/rtl/stq_mark_file.sv]
// ----------------------------------------------------------------------------
// Slot mark file
// Free / allocated / queued mark per slot, cleared by reset.
// ----------------------------------------------------------------------------
module stq_mark_file #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [AW-1:0]         rd_addr,
   output stq_pkg::stq_mark_type rd_mark,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  stq_pkg::stq_mark_type wr_mark
);

   stq_pkg::stq_mark_type mark_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            mark_ff[i] <= stq_pkg::MARK_FREE;
         end
      end else if (wr_en) begin
         mark_ff[wr_addr] <= wr_mark;
      end
   end

   assign rd_mark = mark_ff[rd_addr];

endmodule
